// ===== design/modexp_pkg.sv =====
`default_nettype none

package modexp_pkg;

	// fixed widths of the port words
	localparam int BASE_W = 64;
	localparam int EXP_W  = 64;
	localparam int MOD_W  = 32;
	localparam int RES_W  = 32;

	// default sizes of the stored operands
	localparam int DEF_EXP_BITS = 64;
	localparam int DEF_MOD_BITS = 32;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED,
		ST_NEXT,
		ST_MUL,
		ST_SQR,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

// ===== design/modular_exponentiation.sv =====
`default_nettype none

// Modular exponentiation, right-to-left binary square-and-multiply. Raise start
// while busy is low to hand in a word (base_value, exponent, modulus); busy then
// stays high until the result has been shown. The result appears on power_result
// for exactly one cycle, marked by done, and must be taken in that cycle: the
// receiver cannot stall the block. Only the low EXP_BITS bits of exponent and the
// low MOD_BITS bits of modulus are used; a zero modulus gives 0, a zero exponent
// gives 1. All arithmetic runs on one shared shift-add-reduce unit that handles a
// single operand bit per cycle. After accept the base is reduced modulo the
// modulus one base bit at a time; then each scanned exponent bit costs a decision
// step and a modular square, and each set bit a modular multiply before the
// square. The scan stops after the highest set bit, so a zero exponent goes
// straight from the base reduction to the result. A zero modulus skips all of
// this and goes from accept straight to the result.
module modular_exponentiation
	import modexp_pkg::*;
#(
	parameter int EXP_BITS = DEF_EXP_BITS,
	parameter int MOD_BITS = DEF_MOD_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [BASE_W-1:0] base_value,
	input  wire logic [EXP_W-1:0]  exponent,
	input  wire logic [MOD_W-1:0]  modulus,
	output logic                   done,
	output logic [RES_W-1:0]       power_result
);

	localparam int CNT_W = (BASE_W > MOD_BITS) ? $clog2(BASE_W) : $clog2(MOD_BITS);
	localparam int SUM_W = MOD_BITS + 2;

	state_t state_q, state_nxt;

	logic [CNT_W-1:0]    cnt_q;
	logic [BASE_W-1:0]   base_q;
	logic [EXP_BITS-1:0] exp_q;
	logic [MOD_BITS-1:0] mod_q;
	logic [MOD_BITS-1:0] acc_q;
	logic [MOD_BITS-1:0] b_q;
	logic [MOD_BITS-1:0] mpy_q;
	logic [MOD_BITS-1:0] r_q;

	logic                mod_zero;
	logic [MOD_BITS-1:0] addend;
	logic [SUM_W-1:0]    sum;
	logic [SUM_W-1:0]    mod_ext;
	logic [SUM_W-1:0]    sub1;
	logic [SUM_W-1:0]    sub2;
	logic [MOD_BITS-1:0] step_r;
	logic                cnt_last;

	assign mod_zero = (modulus[MOD_BITS-1:0] == '0);
	assign cnt_last = (cnt_q == '0);

	// shared unit: r = (2r + addend) mod m, with r below m and addend at most m
	always_comb begin
		if (state_q == ST_RED) begin
			addend = MOD_BITS'(base_q[BASE_W-1]);
		end else begin
			addend = mpy_q[MOD_BITS-1] ? b_q : '0;
		end
		mod_ext = SUM_W'(mod_q);
		sum     = SUM_W'({r_q, 1'b0}) + SUM_W'(addend);
		sub1    = (sum >= mod_ext) ? (sum - mod_ext) : sum;
		sub2    = (sub1 >= mod_ext) ? (sub1 - mod_ext) : sub1;
		step_r  = sub2[MOD_BITS-1:0];
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = mod_zero ? ST_OUT : ST_RED;
				end
			end
			ST_RED: begin
				if (cnt_last) begin
					state_nxt = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (exp_q == '0) begin
					state_nxt = ST_OUT;
				end else if (exp_q[0]) begin
					state_nxt = ST_MUL;
				end else begin
					state_nxt = ST_SQR;
				end
			end
			ST_MUL: begin
				if (cnt_last) begin
					state_nxt = ST_SQR;
				end
			end
			ST_SQR: begin
				if (cnt_last) begin
					state_nxt = ST_NEXT;
				end
			end
			ST_OUT: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// handshake outputs
	always_comb begin
		busy = (state_q != ST_IDLE);
		done = (state_q == ST_OUT);
	end

	assign power_result = RES_W'(acc_q);

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			unique case (state_q)
				ST_IDLE: cnt_q <= CNT_W'(BASE_W - 1);
				ST_NEXT: cnt_q <= CNT_W'(MOD_BITS - 1);
				ST_RED, ST_SQR: cnt_q <= cnt_q - 1'b1;
				ST_MUL: cnt_q <= cnt_last ? CNT_W'(MOD_BITS - 1) : cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// operand registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					base_q <= base_value;
					exp_q  <= exponent[EXP_BITS-1:0];
					mod_q  <= modulus[MOD_BITS-1:0];
					acc_q  <= mod_zero ? '0 : MOD_BITS'(1);
					r_q    <= '0;
				end
			end
			// base reduction, one base bit per cycle from the top
			ST_RED: begin
				r_q    <= step_r;
				base_q <= base_q << 1;
				if (cnt_last) begin
					b_q <= step_r;
				end
			end
			// pick multiply or square for the current exponent bit
			ST_NEXT: begin
				r_q   <= '0;
				mpy_q <= exp_q[0] ? acc_q : b_q;
			end
			// acc = acc * b mod m
			ST_MUL: begin
				r_q   <= step_r;
				mpy_q <= mpy_q << 1;
				if (cnt_last) begin
					acc_q <= step_r;
					r_q   <= '0;
					mpy_q <= b_q;
				end
			end
			// b = b * b mod m, then drop the exponent bit
			ST_SQR: begin
				r_q   <= step_r;
				mpy_q <= mpy_q << 1;
				if (cnt_last) begin
					b_q   <= step_r;
					exp_q <= exp_q >> 1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/modexp_checker.sv =====
`default_nettype none

module modexp_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);

	// an accepted word makes the block busy at once
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
	else $error("block not busy after accepting a word");

	// a result is only shown while the word is still held
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
	else $error("result strobe outside a busy period");

	// the strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
	else $error("result strobe longer than one cycle");

	// the block frees up right after its result
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
	else $error("block still busy after its result");

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import modexp_pkg::*;

	localparam int RANDOM_WORDS = 1630;
	localparam longint CYCLE_LIMIT = 30_000_000;
	localparam int DRAIN_CYCLES = 100;

	// one input word of the exponentiator
	typedef struct packed {
		logic [BASE_W-1:0] base_v;
		logic [EXP_W-1:0]  expo;
		logic [MOD_W-1:0]  modu;
	} mx_word_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [BASE_W-1:0] base_value = '0;
	logic [EXP_W-1:0]  exponent = '0;
	logic [MOD_W-1:0]  modulus = '0;
	logic              done;
	logic [RES_W-1:0]  power_result;

	mx_word_t         pending_words[$];
	logic [RES_W-1:0] expected_powers[$];
	logic             taken = 1'b0;
	int               gap_left = 0;
	int               steady_left = 0;
	int               fail_count = 0;
	int               accepted_count = 0;
	int               result_count = 0;
	int               directed_count = 0;
	longint           cycle_count = 0;

	modular_exponentiation u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.base_value  (base_value),
		.exponent    (exponent),
		.modulus     (modulus),
		.done        (done),
		.power_result(power_result)
	);

	always #5 clk = ~clk;

	// right-to-left square-and-multiply on 64-bit intermediates
	function automatic logic [RES_W-1:0] modpow_expected(input logic [BASE_W-1:0] b_in,
			input logic [EXP_W-1:0] e_in, input logic [MOD_W-1:0] m_in);
		logic [63:0] m;
		logic [63:0] b;
		logic [63:0] e;
		logic [63:0] acc;
		e = 64'(e_in & ({EXP_W{1'b1}} >> (EXP_W - DEF_EXP_BITS)));
		m = 64'(m_in & ({MOD_W{1'b1}} >> (MOD_W - DEF_MOD_BITS)));
		if (m == 64'd0)
			return '0;
		acc = 64'd1;
		b = b_in % m;
		while (e != 64'd0) begin
			if (e[0])
				acc = (acc * b) % m;
			e = e >> 1;
			b = (b * b) % m;
		end
		return acc[RES_W-1:0];
	endfunction

	task automatic report_mismatch(input string what, input logic [RES_W-1:0] got,
			input logic [RES_W-1:0] want);
		if (fail_count < 20)
			$display("mismatch at cycle %0d: %s, got %h expected %h", cycle_count, what, got,
				want);
		fail_count++;
	endtask

	task automatic add_word(input logic [BASE_W-1:0] b, input logic [EXP_W-1:0] e,
			input logic [MOD_W-1:0] m);
		mx_word_t w;
		w.base_v = b;
		w.expo = e;
		w.modu = m;
		pending_words.push_back(w);
	endtask

	// idle length: mostly short, a few long, with stretches of none
	function automatic int pick_gap();
		int r;
		if (steady_left > 0) begin
			steady_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			steady_left = $urandom_range(10, 40);
			return 0;
		end
		if (r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// driver: hold a word until taken, then idle a while once the block is free
	always @(negedge clk) begin
		mx_word_t w;
		if (arst_n) begin
			if (!(start && !taken)) begin
				if (gap_left != 0) begin
					start <= 1'b0;
					base_value <= {$urandom, $urandom};
					exponent <= {$urandom, $urandom};
					modulus <= $urandom;
					if (!busy)
						gap_left <= gap_left - 1;
				end else if (pending_words.size() != 0) begin
					w = pending_words.pop_front();
					base_value <= w.base_v;
					exponent <= w.expo;
					modulus <= w.modu;
					start <= 1'b1;
					gap_left <= pick_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: predict on accept, check each strobed result
	always @(posedge clk) begin
		logic [RES_W-1:0] want;
		if (!arst_n) begin
			taken <= 1'b0;
		end else begin
			taken <= start && !busy;
			if (start && !busy) begin
				expected_powers.push_back(modpow_expected(base_value, exponent, modulus));
				accepted_count++;
			end
			if (done === 1'b1) begin
				if (expected_powers.size() == 0) begin
					report_mismatch("result with nothing pending", power_result, '0);
				end else begin
					want = expected_powers.pop_front();
					result_count++;
					if (power_result !== want)
						report_mismatch("power_result", power_result, want);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		mx_word_t w;
		int pick;

		// directed words: edge fields and special cases
		add_word({$urandom, $urandom}, {$urandom, $urandom}, 32'd0);
		add_word('1, '1, 32'd0);
		add_word({$urandom, $urandom}, 64'd0, 32'd1);
		add_word({$urandom, $urandom}, 64'd0, 32'd7);
		add_word('1, 64'd0, '1);
		add_word(64'd0, 64'd0, 32'd5);
		add_word({$urandom, $urandom}, 64'd5, 32'd1);
		add_word(64'd0, 64'd3, 32'd13);
		add_word('1, '1, '1);
		add_word('1, '1, 32'hFFFF_FFFB);
		add_word(64'd2, 64'd10, 32'd1000);
		add_word(64'd3, 64'h8000_0000_0000_0000, 32'd1_000_000_007);
		add_word(64'd1_000_000_007, 64'd1, 32'd1_000_000_007);
		add_word(64'hFFFF_FFFE, 64'd2, 32'hFFFF_FFFF);
		add_word({$urandom, $urandom}, {$urandom, $urandom}, 32'd2);
		add_word('1, 64'd1, 32'h8000_0000);
		add_word({$urandom, $urandom}, 64'hAAAA_AAAA_AAAA_AAAA, 32'h8000_0001);
		add_word({$urandom, $urandom}, 64'h5555_5555_5555_5555, 32'h7FFF_FFFF);
		add_word(64'h8000_0000_0000_0000, 64'd1, 32'd3);
		add_word(64'd1, '1, 32'd65_537);
		directed_count = pending_words.size();

		// random words: mostly short exponents, a few full width
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 60)
				w.expo = 64'($urandom_range(0, 255));
			else if (pick < 85)
				w.expo = 64'($urandom_range(0, 65535));
			else if (pick < 95)
				w.expo = 64'($urandom);
			else
				w.expo = {$urandom, $urandom};
			pick = $urandom_range(0, 99);
			if (pick < 3)
				w.modu = 32'd0;
			else if (pick < 13)
				w.modu = 32'($urandom_range(1, 16));
			else if (pick < 18)
				w.modu = 32'd1 << $urandom_range(1, 31);
			else if (pick < 25)
				w.modu = ~32'($urandom_range(0, 255));
			else
				w.modu = $urandom;
			pick = $urandom_range(0, 99);
			if (pick < 10)
				w.base_v = 64'($urandom_range(0, 3));
			else if (pick < 20)
				w.base_v = ~64'($urandom_range(0, 255));
			else
				w.base_v = {$urandom, $urandom};
			pending_words.push_back(w);
		end

		// reset
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// wait for every word to be taken and answered
		while (pending_words.size() != 0 || start || expected_powers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d words sent (%0d directed, %0d random), %0d results checked",
			accepted_count, directed_count, accepted_count - directed_count, result_count);
		$display("%0d mismatches seen over %0d cycles", fail_count, cycle_count);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
design/modexp_pkg.sv
design/modular_exponentiation.sv
design/modexp_checker.sv
test/tb.sv
